// File: hdl/dcnt_pkg.sv
// ----------------------------------------------------------------------------
// dcnt_pkg
// Shared types, constants and the control store of the divisor counter.
// ----------------------------------------------------------------------------
`default_nettype none

package dcnt_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int IN_TDATA_W     = 32;
    localparam int COUNT_W        = 11;
    localparam int OUT_TDATA_W    = 16;
    localparam int STEP_W         = 5;

    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_CLR,
        OP_SHR,
        OP_MULE,
        OP_SETD,
        OP_SQ,
        OP_DIVGO,
        OP_TAKE,
        OP_NEXTD,
        OP_DBL,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_IN,
        C_N_ZERO,
        C_N_ODD,
        C_SQ_GT_N,
        C_DIV_BUSY,
        C_REM_NZ,
        C_N_LE1,
        C_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic n_zero;
        logic n_odd;
        logic n_le1;
        logic sq_gt_n;
        logic div_busy;
        logic rem_nz;
        logic out_full;
    } status_t;

    localparam step_t ST_IDLE  = 5'd0;
    localparam step_t ST_CHKZ  = 5'd1;
    localparam step_t ST_EVEN  = 5'd2;
    localparam step_t ST_SHIFT = 5'd3;
    localparam step_t ST_MUL2  = 5'd4;
    localparam step_t ST_SETD  = 5'd5;
    localparam step_t ST_LOOP  = 5'd6;
    localparam step_t ST_TEST  = 5'd7;
    localparam step_t ST_DIVGO = 5'd8;
    localparam step_t ST_DIVW  = 5'd9;
    localparam step_t ST_CHKR  = 5'd10;
    localparam step_t ST_TAKE  = 5'd11;
    localparam step_t ST_MULE  = 5'd12;
    localparam step_t ST_NEXTD = 5'd13;
    localparam step_t ST_TAIL  = 5'd14;
    localparam step_t ST_DBL   = 5'd15;
    localparam step_t ST_EMIT  = 5'd16;
    localparam step_t ST_BACK  = 5'd17;
    localparam step_t ST_ZERO  = 5'd18;

    // control store: jump to target when the condition holds, else fall through
    function automatic ctrl_word_t rom_word(input step_t addr);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: ST_IDLE};
        unique case (addr)
            ST_IDLE:  w = '{op: OP_LOAD,  cond: C_NO_IN,    target: ST_IDLE};
            ST_CHKZ:  w = '{op: OP_NOP,   cond: C_N_ZERO,   target: ST_ZERO};
            ST_EVEN:  w = '{op: OP_NOP,   cond: C_N_ODD,    target: ST_MUL2};
            ST_SHIFT: w = '{op: OP_SHR,   cond: C_ALWAYS,   target: ST_EVEN};
            ST_MUL2:  w = '{op: OP_MULE,  cond: C_NEXT,     target: ST_IDLE};
            ST_SETD:  w = '{op: OP_SETD,  cond: C_NEXT,     target: ST_IDLE};
            ST_LOOP:  w = '{op: OP_SQ,    cond: C_NEXT,     target: ST_IDLE};
            ST_TEST:  w = '{op: OP_NOP,   cond: C_SQ_GT_N,  target: ST_TAIL};
            ST_DIVGO: w = '{op: OP_DIVGO, cond: C_NEXT,     target: ST_IDLE};
            ST_DIVW:  w = '{op: OP_NOP,   cond: C_DIV_BUSY, target: ST_DIVW};
            ST_CHKR:  w = '{op: OP_NOP,   cond: C_REM_NZ,   target: ST_MULE};
            ST_TAKE:  w = '{op: OP_TAKE,  cond: C_ALWAYS,   target: ST_DIVGO};
            ST_MULE:  w = '{op: OP_MULE,  cond: C_NEXT,     target: ST_IDLE};
            ST_NEXTD: w = '{op: OP_NEXTD, cond: C_ALWAYS,   target: ST_LOOP};
            ST_TAIL:  w = '{op: OP_NOP,   cond: C_N_LE1,    target: ST_EMIT};
            ST_DBL:   w = '{op: OP_DBL,   cond: C_NEXT,     target: ST_IDLE};
            ST_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_FULL, target: ST_EMIT};
            ST_BACK:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: ST_IDLE};
            ST_ZERO:  w = '{op: OP_CLR,   cond: C_ALWAYS,   target: ST_EMIT};
            default:  w = '{op: OP_NOP,   cond: C_ALWAYS,   target: ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: hdl/dcnt_div.sv
// ----------------------------------------------------------------------------
// dcnt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dcnt_div #(
    parameter int VALUE_BITS = dcnt_pkg::VALUE_BITS_DEF,
    parameter int DIVISOR_W  = (VALUE_BITS + 1) / 2 + 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [VALUE_BITS-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       busy,
    output logic [VALUE_BITS-1:0]      quotient,
    output logic [DIVISOR_W-1:0]       remainder
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[VALUE_BITS-1]};
        diff      = shifted - {1'b0, dsr_reg};
        fits      = (shifted >= {1'b0, dsr_reg});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS);
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quot_next = {quot_reg[VALUE_BITS-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// File: hdl/dcnt_dp.sv
// ----------------------------------------------------------------------------
// dcnt_dp
// Datapath: cofactor, candidate, exponent and count registers, output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dcnt_dp #(
    parameter int VALUE_BITS = dcnt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dcnt_pkg::ctrl_word_t              ctrl,
    output dcnt_pkg::status_t                      status,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dcnt_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [dcnt_pkg::OUT_TDATA_W-1:0]       m_tdata
);

    localparam int DW  = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQW = 2 * DW;
    localparam int EW  = $clog2(VALUE_BITS + 1);
    localparam int CW  = dcnt_pkg::COUNT_W;

    logic [VALUE_BITS-1:0] n_reg, n_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [SQW-1:0]        sq_reg, sq_next;
    logic [EW-1:0]         e_reg, e_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [CW-1:0]         m_count_reg, m_count_next;
    logic [EW-1:0]         e_inc;
    logic [CW+EW-1:0]      prod;
    logic                  out_full;
    logic                  div_start;
    logic                  div_busy;
    logic [VALUE_BITS-1:0] div_quot;
    logic [DW-1:0]         div_rem;

    dcnt_div #(
        .VALUE_BITS (VALUE_BITS),
        .DIVISOR_W  (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .busy      (div_busy),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign e_inc     = e_reg + EW'(1);
    assign prod      = count_reg * e_inc;
    assign out_full  = m_tvalid_reg && !m_tready;
    assign div_start = (ctrl.op == dcnt_pkg::OP_DIVGO);
    assign s_tready  = (ctrl.op == dcnt_pkg::OP_LOAD);

    always_comb
    begin
        n_next        = n_reg;
        d_next        = d_reg;
        sq_next       = sq_reg;
        e_next        = e_reg;
        count_next    = count_reg;
        m_count_next  = m_count_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (ctrl.op)
            dcnt_pkg::OP_LOAD:
            begin
                if (s_tvalid)
                begin
                    n_next     = s_tdata[VALUE_BITS-1:0];
                    e_next     = '0;
                    count_next = CW'(1);
                end
            end
            dcnt_pkg::OP_CLR:   count_next = '0;
            dcnt_pkg::OP_SHR:
            begin
                n_next = n_reg >> 1;
                e_next = e_inc;
            end
            dcnt_pkg::OP_MULE:
            begin
                count_next = prod[CW-1:0];
                e_next     = '0;
            end
            dcnt_pkg::OP_SETD:  d_next = DW'(3);
            dcnt_pkg::OP_SQ:    sq_next = d_reg * d_reg;
            dcnt_pkg::OP_TAKE:
            begin
                n_next = div_quot;
                e_next = e_inc;
            end
            dcnt_pkg::OP_NEXTD: d_next = d_reg + DW'(2);
            dcnt_pkg::OP_DBL:   count_next = {count_reg[CW-2:0], 1'b0};
            dcnt_pkg::OP_EMIT:
            begin
                if (!out_full)
                begin
                    m_tvalid_next = 1'b1;
                    m_count_next  = count_reg;
                end
            end
            dcnt_pkg::OP_NOP, dcnt_pkg::OP_DIVGO: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        e_reg       <= e_next;
        count_reg   <= count_next;
        m_count_reg <= m_count_next;
    end

    always_comb
    begin
        status.in_valid = s_tvalid;
        status.n_zero   = (n_reg == '0);
        status.n_odd    = n_reg[0];
        status.n_le1    = (n_reg <= VALUE_BITS'(1));
        status.sq_gt_n  = (sq_reg > SQW'(n_reg));
        status.div_busy = div_busy;
        status.rem_nz   = (div_rem != '0);
        status.out_full = out_full;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(dcnt_pkg::OUT_TDATA_W - CW){1'b0}}, m_count_reg};

`ifndef SYNTHESIS
    a_div_starts: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> div_busy)
        else $error("divider did not start");

    a_shift_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == dcnt_pkg::OP_SHR) |-> (n_reg != '0))
        else $error("shifting a zero cofactor");

    a_take_exact: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == dcnt_pkg::OP_TAKE) |-> (!div_busy && div_rem == '0))
        else $error("quotient taken from an inexact division");

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == dcnt_pkg::OP_EMIT && !out_full) |=> m_tvalid_reg)
        else $error("result not presented");
`endif

endmodule

`default_nettype wire

// File: hdl/dcnt_seq.sv
// ----------------------------------------------------------------------------
// dcnt_seq
// Microcode sequencer: step counter, control store and jump logic.
// ----------------------------------------------------------------------------
`default_nettype none

module dcnt_seq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dcnt_pkg::status_t    status,
    output dcnt_pkg::ctrl_word_t      ctrl
);

    dcnt_pkg::step_t upc_reg, upc_next;
    logic            take_jump;

    assign ctrl = dcnt_pkg::rom_word(upc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            dcnt_pkg::C_NEXT:     take_jump = 1'b0;
            dcnt_pkg::C_ALWAYS:   take_jump = 1'b1;
            dcnt_pkg::C_NO_IN:    take_jump = !status.in_valid;
            dcnt_pkg::C_N_ZERO:   take_jump = status.n_zero;
            dcnt_pkg::C_N_ODD:    take_jump = status.n_odd;
            dcnt_pkg::C_SQ_GT_N:  take_jump = status.sq_gt_n;
            dcnt_pkg::C_DIV_BUSY: take_jump = status.div_busy;
            dcnt_pkg::C_REM_NZ:   take_jump = status.rem_nz;
            dcnt_pkg::C_N_LE1:    take_jump = status.n_le1;
            dcnt_pkg::C_OUT_FULL: take_jump = status.out_full;
            default:              take_jump = 1'b1;
        endcase
        upc_next = take_jump ? ctrl.target : upc_reg + dcnt_pkg::STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= dcnt_pkg::ST_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

`ifndef SYNTHESIS
    a_upc_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        upc_reg <= dcnt_pkg::ST_ZERO)
        else $error("step counter left the program");

    a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == dcnt_pkg::ST_DIVW && status.div_busy) |=>
        (upc_reg == dcnt_pkg::ST_DIVW))
        else $error("left division wait early");

    a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == dcnt_pkg::ST_EMIT && !status.out_full) |=>
        (upc_reg == dcnt_pkg::ST_BACK))
        else $error("emit step misrouted");
`endif

endmodule

`default_nettype wire

// File: hdl/divisor_count_by_trial_division_top.sv
// ----------------------------------------------------------------------------
// divisor_count_by_trial_division_top
// Divisor count (tau) of an unsigned integer by trial division.
// ----------------------------------------------------------------------------
// Input stream s_*: one transaction carries the value, low VALUE_BITS used.
// Output stream m_*: one transaction per input, the number of divisors
// (zero for a zero input).
// One value is worked at a time; s_tready is high only in the idle step.
// Odd candidates run up to the square root of the cofactor, each tried by
// a division on the one-bit-per-cycle divider; this divider sets the time
// a value takes, so a prime near 2^32 is among the slowest inputs.
// The result sits in an output register. The next value is taken while it
// waits; if the receiver still stalls when that value is done, the block
// holds in its emit step and s_tready stays low until the register frees.
// A stall never loses or repeats a transaction.
// Reset clears the step counter and output valid; the block is then idle.
// ----------------------------------------------------------------------------
`default_nettype none

module divisor_count_by_trial_division_top #(
    parameter int VALUE_BITS = dcnt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [dcnt_pkg::IN_TDATA_W-1:0]   s_tdata,  // [31:0] value
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [dcnt_pkg::OUT_TDATA_W-1:0]       m_tdata   // [10:0] divisor_count
);

    dcnt_pkg::ctrl_word_t ctrl;
    dcnt_pkg::status_t    status;

    dcnt_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    dcnt_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire

// File: dv/divisor_count_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// divisor_count_checker
// Watches both streams of the divisor counter and checks every count.
// Each accepted value is factored here by trial division. Its divisor count
// is queued, and every result transaction is compared with the oldest
// queued count. Exports the running error tally and the number of counts
// still outstanding.
// ----------------------------------------------------------------------------
module divisor_count_checker #(
    parameter int VALUE_BITS = dcnt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [dcnt_pkg::IN_TDATA_W-1:0]   s_tdata,  // [31:0] value
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [dcnt_pkg::OUT_TDATA_W-1:0]  m_tdata,  // [10:0] divisor_count
    output int                                     errors,
    output int                                     pending
);

    typedef logic [dcnt_pkg::COUNT_W-1:0] count_t;

    count_t expected_counts[$];
    int     error_tally = 0;

    function automatic count_t count_divisors(input logic [dcnt_pkg::IN_TDATA_W-1:0] raw);
        longint unsigned n;
        longint unsigned d;
        longint unsigned product;
        longint unsigned mask;
        int unsigned     e;
        mask = (64'd1 << VALUE_BITS) - 64'd1;
        n    = 64'(raw) & mask & 64'hFFFF_FFFF;
        if (n == 0)
            return '0;
        product = 1;
        e = 0;
        while (n[0] == 1'b0)
        begin
            n = n >> 1;
            e++;
        end
        product = product * (e + 1);
        for (d = 3; d * d <= n; d += 2)
        begin
            e = 0;
            while (n % d == 0)
            begin
                n = n / d;
                e++;
            end
            product = product * (e + 1);
        end
        // leftover prime above the square root
        if (n > 1)
            product = product * 2;
        return product[dcnt_pkg::COUNT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        error_tally++;
    endtask

    always @(posedge clk)
    begin
        count_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_counts.size() == 0)
                    report_mismatch($sformatf("count %0d with no value outstanding",
                                              m_tdata[dcnt_pkg::COUNT_W-1:0]));
                else
                begin
                    want = expected_counts.pop_front();
                    if (m_tdata[dcnt_pkg::COUNT_W-1:0] !== want)
                        report_mismatch($sformatf("divisor_count %0d, expected %0d",
                                                  m_tdata[dcnt_pkg::COUNT_W-1:0], want));
                end
            end
            if (s_tvalid && s_tready)
                expected_counts.push_back(count_divisors(s_tdata));
        end
        pending <= expected_counts.size();
        errors  <= error_tally;
    end

endmodule

// File: dv/tb_divisor_count_by_trial_division_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_divisor_count_by_trial_division_top
// Stimulus and verdict for the divisor counter.
// Corner values first, then a receiver hold-off, then random values under
// several idle and stall mixes. Random values are mostly built from small
// factors so that trial division stays short while all input bits move.
// Checking is done by divisor_count_checker.
// ----------------------------------------------------------------------------
module tb_divisor_count_by_trial_division_top;

    localparam int QUIET_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 20000;
    localparam int ITEMS_PER_MIX = 18;

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [dcnt_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;   // [31:0] value
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [dcnt_pkg::OUT_TDATA_W-1:0] m_tdata;         // [10:0] divisor_count

    int errors;
    int pending;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    int unsigned small_primes[16] = '{3, 5, 7, 11, 13, 17, 19, 23,
                                      29, 31, 37, 41, 43, 97, 101, 251};

    // zero, one, primes, squares, leftover prime, highly composite, bit patterns
    logic [31:0] corner_values[20] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd9, 32'd49, 32'd202,
        32'd4093, 32'd65521, 32'd1048573, 32'h8000_0000, 32'hFFFF_FFFF,
        32'hAAAA_AAAA, 32'h5555_5555, 32'd735134400, 32'd3486784401,
        32'd65537, 32'd2310, 32'd1024
    };

    divisor_count_by_trial_division_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    divisor_count_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [31:0] pick_value();
        longint unsigned v;
        longint unsigned p;
        int unsigned     kind;
        kind = $urandom_range(0, 9);
        if (kind < 3)
            v = $urandom_range(0, 4095);
        else if (kind < 9)
        begin
            // smooth value: one factor up to 4095, small primes, then twos
            v = $urandom_range(1, 4095);
            repeat ($urandom_range(1, 9))
            begin
                p = small_primes[$urandom_range(0, 15)];
                if (v * p <= 64'hFFFF_FFFF)
                    v = v * p;
            end
            while (v < 64'h8000_0000 && $urandom_range(0, 2) != 0)
                v = v << 1;
        end
        else
        begin
            v = 64'(small_primes[$urandom_range(0, 15)]) << $urandom_range(0, 23);
            if (v > 64'hFFFF_FFFF)
                v = v >> 8;
        end
        return v[31:0];
    endfunction

    task automatic send_value(input logic [31:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic run_mix(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        repeat (ITEMS_PER_MIX)
            send_value(pick_value());
        wait_drained();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_values[i])
            send_value(corner_values[i]);
        wait_drained();

        // receiver holds off while values keep coming, then sender waits
        hold_requests <= hold_requests + 1;
        repeat (6)
            send_value(pick_value());
        wait_drained();

        run_mix(0, 0);
        run_mix(72, 0);
        run_mix(0, 72);
        run_mix(7, 7);

        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
